[rtl/tppc_pkg.sv]
// Package for the transformed polygon point containment unit.
// Holds widths, register indexes, request types, the state enum and the cell control struct; no dependencies.
`timescale 1ns / 1ps
package tppc_pkg;
    localparam int COORD_W = 24;
    localparam int TRIG_W  = 16;
    localparam int SCALE_W = 16;
    localparam int COUNT_W = 5;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd5;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XFORM,
        ST_SCAN,
        ST_DONE
    } t_state;

    // control handed to every cell
    typedef struct packed {
        logic load;   // write one vertex into the chain
        logic shift;  // rotate the chain by one slot
    } t_cell_ctl;
endpackage

[rtl/transformed_polygon_point_containment_unit.sv]
// Transformed polygon point containment unit: vertex ring of cells, transform
// pipeline, edge tester and the sequencer. Depends on tppc_pkg and submodules.
// Sequence: a write is taken when idle; a query runs a lead step (r_pre) for a nonzero
// count, a full ring turn in ST_XFORM, a drain through transform and edge in ST_SCAN,
// then ST_DONE and the registered o_done; count 0 goes straight to ST_SCAN.
// Throughput: one query at a time; busy stays high through o_done. Results cannot stall.
// Reset: synchronous active low; config returns to identity, vertices undefined.
`timescale 1ns / 1ps
module transformed_polygon_point_containment_unit #(
    parameter int MAX_VERTICES = tppc_pkg::DEF_MAX_VERTICES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic [tppc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tppc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_req_type,
    input  logic [3:0]                             i_vertex_index,
    input  logic signed [tppc_pkg::COORD_W-1:0]    i_coord_x,
    input  logic signed [tppc_pkg::COORD_W-1:0]    i_coord_y,
    output logic                                   o_done,
    output logic                                   o_inside_res
);
    import tppc_pkg::*;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int N_W   = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W = (N_W > COUNT_W ? N_W : COUNT_W) + 1;
    localparam int XF_LAT = 3;

    logic signed [COORD_W-1:0] r_org_x, r_org_y, r_px, r_py;
    logic signed [TRIG_W-1:0]  r_cos, r_sin;
    logic [SCALE_W-1:0]        r_scale;
    logic [COUNT_W-1:0]        r_count;
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt, w_n;
    logic [XF_LAT-1:0]         r_vpipe, r_ppipe;
    logic                      r_done, r_res;
    t_cell_ctl                 w_ctl;
    logic                      w_acc, w_issue, w_prime, w_clear;

    logic signed [COORD_W-1:0] w_cx [MAX_VERTICES];
    logic signed [COORD_W-1:0] w_cy [MAX_VERTICES];
    logic signed [COORD_W-1:0] w_wx, w_wy;
    logic                      w_flag;

    assign w_acc = start && !busy;
    assign w_n = (CNT_W'(r_count) > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                        : CNT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_cos   <= 16'sd16384;
            r_sin   <= '0;
            r_scale <= 16'd256;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_org_x <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y: r_org_y <= i_cfg_data[COORD_W-1:0];
                REG_COS:      r_cos   <= i_cfg_data[TRIG_W-1:0];
                REG_SIN:      r_sin   <= i_cfg_data[TRIG_W-1:0];
                REG_SCALE:    r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_COUNT:    r_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_req_type == REQ_QUERY) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
    end

    // ring: cell k takes cell k+1; cell 0 feeds the transform. Cell M-1 wraps to cell 0;
    // the first vertex out is the last one (the initial previous vertex), from a side tap.
    always_comb begin
        w_ctl.load  = w_acc && i_req_type == REQ_WRITE;
        w_ctl.shift = w_issue;
    end

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        logic signed [COORD_W-1:0] w_nx, w_ny;
        logic w_sel;
        always_comb begin
            w_sel = (32'(i_vertex_index) == k);
            // last cell wraps to cell 0
            w_nx = w_cx[(k + 1) % MAX_VERTICES];
            w_ny = w_cy[(k + 1) % MAX_VERTICES];
        end
        tppc_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_sel  (w_sel),
            .i_wr_x (i_coord_x),
            .i_wr_y (i_coord_y),
            .i_nb_x (w_nx),
            .i_nb_y (w_ny),
            .o_x    (w_cx[k]),
            .o_y    (w_cy[k])
        );
    end

    // The ring makes one full turn of M shifts and so ends back at home.
    // A lead step (r_pre) before the turn reads vertex n-1 from a side tap.
    // Schedule in ST_XFORM: r_cnt counts shifts 0..M-1; shift every cycle.
    // Issue vertex from cell 0 when shift index s maps to a real vertex.
    logic w_cap;
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_acc && i_req_type == REQ_QUERY)
                    n_state = (w_n == '0) ? ST_SCAN : ST_XFORM;
            end
            ST_XFORM: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAX_VERTICES - 1)) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(XF_LAT + 2)) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // In ST_XFORM the ring shifts M times; cell 0 shows vertex r_cnt.
    // Vertex n-1 must go first: it is fed from a side tap in the lead step (r_pre).
    assign w_issue = (r_state == ST_XFORM);
    assign w_cap   = w_issue && (r_cnt < w_n);

    logic signed [COORD_W-1:0] w_fx, w_fy;
    logic [IDX_W-1:0]          w_last;
    logic                      r_pre;
    assign w_last = IDX_W'(w_n - 1'b1);
    always_comb begin
        if (r_pre) begin
            w_fx = w_cx[w_last];
            w_fy = w_cy[w_last];
        end else begin
            w_fx = w_cx[0];
            w_fy = w_cy[0];
        end
    end

    // r_pre: a lead step before the rotation feeds the last vertex
    logic w_feed;
    assign w_feed  = r_pre || w_cap;
    assign w_prime = r_pre;
    assign w_clear = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_vpipe <= '0;
            r_ppipe <= '0;
            r_pre   <= 1'b0;
            r_done  <= 1'b0;
            r_res   <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && w_acc && i_req_type == REQ_QUERY && w_n != '0) begin
                r_pre   <= 1'b1;
                r_state <= ST_IDLE;
                r_cnt   <= '0;
            end else begin
                r_pre   <= 1'b0;
                r_state <= (r_pre ? ST_XFORM : n_state);
                r_cnt   <= (r_pre ? '0 : n_cnt);
            end
            r_vpipe <= {r_vpipe[XF_LAT-2:0], w_feed};
            r_ppipe <= {r_ppipe[XF_LAT-2:0], w_prime};
            r_done  <= (r_state == ST_DONE);
            r_res   <= w_flag;
        end
    end

    tppc_xform u_xform (
        .i_clk   (i_clk),
        .i_x     (w_fx),
        .i_y     (w_fy),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .i_scale (r_scale),
        .i_org_x (r_org_x),
        .i_org_y (r_org_y),
        .o_wx    (w_wx),
        .o_wy    (w_wy)
    );

    tppc_edge u_edge (
        .i_clk   (i_clk),
        .i_clear (w_clear && !r_pre),
        .i_valid (r_vpipe[XF_LAT-1]),
        .i_prime (r_ppipe[XF_LAT-1]),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ix    (w_wx),
        .i_iy    (w_wy),
        .o_flag  (w_flag)
    );

    assign busy         = (r_state != ST_IDLE) || r_pre || r_done;
    assign o_done       = r_done;
    assign o_inside_res = r_res;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while not busy");
    a_no_feed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !w_feed) else $error("vertex issued at end");
endmodule

[rtl/tppc_cell.sv]
// One cell of the vertex ring: holds one vertex, loads its own slot or
// takes the neighbor's vertex on a rotate. Depends on tppc_pkg.
`timescale 1ns / 1ps
module tppc_cell (
    input  logic                                i_clk,
    input  tppc_pkg::t_cell_ctl                 i_ctl,
    input  logic                                i_sel,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_wr_x,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_wr_y,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_nb_x,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_nb_y,
    output logic signed [tppc_pkg::COORD_W-1:0] o_x,
    output logic signed [tppc_pkg::COORD_W-1:0] o_y
);
    import tppc_pkg::*;
    logic signed [COORD_W-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_sel) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_ctl.shift) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule

[rtl/tppc_xform.sv]
// Per-vertex local-to-world transform, three register stages.
// Rotate, scale, add origin and saturate. Depends on tppc_pkg.
`timescale 1ns / 1ps
module tppc_xform (
    input  logic                                i_clk,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_x,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_y,
    input  logic signed [tppc_pkg::TRIG_W-1:0]  i_cos,
    input  logic signed [tppc_pkg::TRIG_W-1:0]  i_sin,
    input  logic        [tppc_pkg::SCALE_W-1:0] i_scale,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_org_x,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_org_y,
    output logic signed [tppc_pkg::COORD_W-1:0] o_wx,
    output logic signed [tppc_pkg::COORD_W-1:0] o_wy
);
    import tppc_pkg::*;
    localparam int P_W = COORD_W + TRIG_W;     // 40
    localparam int R_W = P_W - 14 + 1;         // 27
    localparam int S_W = R_W + SCALE_W + 1;    // 44
    localparam int W_W = S_W - 8 + 1;          // 37

    logic signed [P_W-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [R_W-1:0] r_rx, r_ry;
    logic signed [W_W-1:0] r_wx, r_wy;
    logic signed [S_W-1:0] w_sx, w_sy;

    function automatic logic signed [R_W-1:0] trunc14(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] a;
        a = p + (p[P_W-1] ? P_W'(16383) : P_W'(0));
        return R_W'(a >>> 14);
    endfunction

    function automatic logic signed [W_W-1:0] trunc8(input logic signed [S_W-1:0] p);
        logic signed [S_W-1:0] a;
        a = p + (p[S_W-1] ? S_W'(255) : S_W'(0));
        return W_W'(a >>> 8);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [W_W-1:0] v);
        if (v > W_W'(8388607)) return 24'sh7FFFFF;
        if (v < -W_W'(8388608)) return 24'sh800000;
        return COORD_W'(v);
    endfunction

    always_comb begin
        w_sx = S_W'(r_rx) * $signed({1'b0, i_scale});
        w_sy = S_W'(r_ry) * $signed({1'b0, i_scale});
    end

    always_ff @(posedge i_clk) begin
        r_xc <= P_W'(i_x) * P_W'(i_cos);
        r_ys <= P_W'(i_y) * P_W'(i_sin);
        r_xs <= P_W'(i_x) * P_W'(i_sin);
        r_yc <= P_W'(i_y) * P_W'(i_cos);
        r_rx <= trunc14(r_xc) - trunc14(r_ys);
        r_ry <= trunc14(r_xs) + trunc14(r_yc);
        r_wx <= W_W'(i_org_x) + trunc8(w_sx);
        r_wy <= W_W'(i_org_y) + trunc8(w_sy);
    end

    assign o_wx = sat(r_wx);
    assign o_wy = sat(r_wy);
endmodule

[rtl/tppc_edge.sv]
// Even-odd edge test, two stages: straddle and products, then compare.
// Keeps the previous world vertex and the crossing parity. Depends on tppc_pkg.
`timescale 1ns / 1ps
module tppc_edge (
    input  logic                                i_clk,
    input  logic                                i_clear,
    input  logic                                i_valid,
    input  logic                                i_prime,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_px,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_py,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_ix,
    input  logic signed [tppc_pkg::COORD_W-1:0] i_iy,
    output logic                                o_flag
);
    import tppc_pkg::*;
    localparam int D_W = COORD_W + 1;
    localparam int M_W = 2 * D_W;

    logic signed [COORD_W-1:0] r_jx, r_jy;
    logic                      r_flag;
    logic                      r_v2, r_hit, r_dpos;
    logic signed [M_W-1:0]     r_lhs, r_rhs;
    logic signed [D_W-1:0]     w_d, w_a, w_b, w_c;
    logic                      w_hit;

    always_comb begin
        w_d = D_W'(r_jy) - D_W'(i_iy);
        w_a = D_W'(r_jx) - D_W'(i_px);
        w_b = D_W'(r_jy) - D_W'(i_py);
        w_c = D_W'(r_jx) - D_W'(i_ix);
        w_hit = (i_iy < i_py && r_jy >= i_py) || (r_jy < i_py && i_iy >= i_py);
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_jx <= i_ix;
            r_jy <= i_iy;
        end
        r_lhs  <= M_W'(w_a) * M_W'(w_d);
        r_rhs  <= M_W'(w_b) * M_W'(w_c);
        r_dpos <= w_d > 0;
        if (i_clear) begin
            r_v2   <= 1'b0;
            r_hit  <= 1'b0;
            r_flag <= 1'b0;
        end else begin
            r_v2  <= i_valid && !i_prime;
            r_hit <= w_hit;
            if (r_v2 && r_hit && (r_dpos ? (r_lhs < r_rhs) : (r_lhs > r_rhs)))
                r_flag <= !r_flag;
        end
    end

    assign o_flag = r_flag;
endmodule
